[design/bmap_pkg.sv]
// ----------------------------------------------------------------------------
// bmap_pkg
// shared types, constants and helper functions of the bump map shader
// ----------------------------------------------------------------------------
package bmap_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int CFG_ADDR_BITS   = 2;

    localparam int RAD_BITS        = 14;
    localparam int ROOT_BITS       = 15;
    localparam int REM_BITS        = 17;
    localparam int SQRT_STEPS      = 15;
    localparam int STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES     = (SQRT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int RADICAND_BITS   = 2 * SQRT_STEPS;

    localparam logic [7:0] GRAD_BIAS = 8'd128;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1
    } cfg_addr_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
        color_t     color;
    } grad_t;

    typedef struct packed {
        logic                root_hi;
        logic [RAD_BITS-1:0] rad;
        color_t              color;
    } dist_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] root;
        logic [REM_BITS-1:0]  rem;
    } sq_t;

    typedef struct packed {
        logic                root_hi;
        logic [RAD_BITS-1:0] rad;
        sq_t                 sq;
        color_t              color;
    } sqrt_t;

    typedef struct packed {
        logic [7:0] fall;
        color_t     color;
    } fall_t;

    // two radicand bits consumed by one square root step
    function automatic logic [1:0] sqrt_pair(logic [RAD_BITS-1:0] rad, int step);
        logic [RADICAND_BITS-1:0] n;
        n = {rad, {(RADICAND_BITS - RAD_BITS){1'b0}}};
        return n[RADICAND_BITS - 1 - 2 * step -: 2];
    endfunction

    // one restoring digit step of the integer square root
    function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
        logic [REM_BITS-1:0] rem_sh;
        logic [REM_BITS-1:0] trial;
        sq_t                 nxt;
        rem_sh = {cur.rem[REM_BITS-3:0], pair};
        trial  = {cur.root, 2'b01};
        if (rem_sh >= trial) begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh;
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

[design/bmap_grad.sv]
// ----------------------------------------------------------------------------
// bmap_grad
// gradient stage: light relative offsets, clamped to 0..255
// ----------------------------------------------------------------------------
module bmap_grad
    import bmap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COORD_BITS-1:0] light_x,
    input  logic [COORD_BITS-1:0] light_y,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pix_x,
    input  logic [COORD_BITS-1:0] pix_y,
    input  logic [7:0]            height_right,
    input  logic [7:0]            height_left,
    input  logic [7:0]            height_below,
    input  logic [7:0]            height_above,
    input  color_t                color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output grad_t                 out_data
);

    localparam int W = COORD_BITS + 3;

    logic          valid_reg;
    grad_t         data_reg;
    grad_t         data_next;
    logic [W-1:0]  gx;
    logic [W-1:0]  gy;

    function automatic logic [7:0] sat_byte(logic [W-1:0] val);
        if (val[W-1]) begin
            return 8'd0;
        end else if (|val[W-2:8]) begin
            return 8'd255;
        end
        return val[7:0];
    endfunction

    always_comb begin
        gx = W'(height_right) - W'(height_left) + W'(light_x) + W'(GRAD_BIAS) - W'(pix_x);
        gy = W'(height_below) - W'(height_above) + W'(light_y) + W'(GRAD_BIAS) - W'(pix_y);
        data_next.u     = sat_byte(gx);
        data_next.v     = sat_byte(gy);
        data_next.color = color;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[design/bmap_dist.sv]
// ----------------------------------------------------------------------------
// bmap_dist
// squared distance stage: (u-128)^2 + (v-128)^2
// ----------------------------------------------------------------------------
module bmap_dist
    import bmap_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  grad_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output dist_t out_data
);

    logic               valid_reg;
    dist_t              data_reg;
    dist_t              data_next;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic [14:0]        dx_sq;
    logic [14:0]        dy_sq;
    logic [15:0]        d2;

    always_comb begin
        dx    = signed'({~in_data.u[7], in_data.u[6:0]});
        dy    = signed'({~in_data.v[7], in_data.v[6:0]});
        dx_sq = 15'(unsigned'(16'(dx) * 16'(dx)));
        dy_sq = 15'(unsigned'(16'(dy) * 16'(dy)));
        d2    = 16'(dx_sq) + 16'(dy_sq);
        // radius of 128 or more gives zero falloff
        data_next.root_hi = |d2[15:RAD_BITS];
        data_next.rad     = d2[RAD_BITS-1:0];
        data_next.color   = in_data.color;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[design/bmap_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// bmap_sqrt_stage
// NUM_STEPS digit steps of the 7.8 radius square root, registered
// ----------------------------------------------------------------------------
module bmap_sqrt_stage
    import bmap_pkg::*;
#(
    parameter int FIRST_STEP = 0,
    parameter int NUM_STEPS  = STEPS_PER_STAGE
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  sqrt_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output sqrt_t out_data
);

    localparam int DONE_STEPS = FIRST_STEP + NUM_STEPS;

    logic  valid_reg;
    sqrt_t data_reg;
    sqrt_t data_next;

    always_comb begin
        data_next = in_data;
        for (int k = 0; k < NUM_STEPS; k++) begin
            data_next.sq = sqrt_step(data_next.sq, sqrt_pair(in_data.rad, FIRST_STEP + k));
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    // partial root squared plus remainder equals the consumed radicand bits
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |->
            (32'(data_reg.sq.root) * 32'(data_reg.sq.root) + 32'(data_reg.sq.rem)) ==
            32'({data_reg.rad, {(RADICAND_BITS - RAD_BITS){1'b0}}}
                >> (RADICAND_BITS - 2 * DONE_STEPS)))
        else $error("square root remainder mismatch");

endmodule

[design/bmap_shade.sv]
// ----------------------------------------------------------------------------
// bmap_shade
// falloff stage and colour scaling stage
// ----------------------------------------------------------------------------
module bmap_shade
    import bmap_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  sqrt_t  in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output color_t out_data
);

    logic        fall_valid_reg;
    fall_t       fall_reg;
    fall_t       fall_next;
    logic        fall_ready;
    logic        out_valid_reg;
    color_t      out_reg;
    color_t      out_next;
    logic [15:0] diff;
    logic [23:0] prod;
    logic [15:0] red_prod;
    logic [15:0] green_prod;
    logic [15:0] blue_prod;

    // falloff = 255 * (32768 - s) >> 15
    always_comb begin
        diff  = 16'(17'h08000 - 17'(in_data.sq.root));
        prod  = {diff, 8'd0} - 24'(diff);
        fall_next.fall  = in_data.root_hi ? 8'd0 : prod[22:15];
        fall_next.color = in_data.color;
    end

    always_comb begin
        red_prod       = fall_reg.color.red   * fall_reg.fall;
        green_prod     = fall_reg.color.green * fall_reg.fall;
        blue_prod      = fall_reg.color.blue  * fall_reg.fall;
        out_next.red   = red_prod[15:8];
        out_next.green = green_prod[15:8];
        out_next.blue  = blue_prod[15:8];
    end

    assign fall_ready = !out_valid_reg || out_ready;
    assign in_ready   = !fall_valid_reg || fall_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                fall_valid_reg <= in_valid;
            end
            if (fall_ready) begin
                out_valid_reg <= fall_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            fall_reg <= fall_next;
        end
        if (fall_ready && fall_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

[design/env_bump_map_shader_unit.sv]
// ----------------------------------------------------------------------------
// env_bump_map_shader_unit
// 2d environment mapped bump map shader; while the output is not stalled, one pixel per clock
// ----------------------------------------------------------------------------
// pipeline: gradient, distance, four square root stages, falloff and
//   colour scaling, each registered between input request and result
// throughput: one pixel per cycle while m_tready accepts results; every stage holds its own valid bit
// reset: aresetn synchronous active low clears valid bits and light position
// ----------------------------------------------------------------------------
module env_bump_map_shader_unit
    import bmap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pix_x, pix_y, height_right, height_left, height_below, height_above,
    // color_red, color_green, color_blue, zero pad
    input  logic [((2*COORD_BITS+56+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // shaded_red, shaded_green, shaded_blue
    output logic [23:0]              m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_data
);

    localparam int HB = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] light_x_reg;
    logic [COORD_BITS-1:0] light_y_reg;
    logic [COORD_BITS-1:0] light_x_next;
    logic [COORD_BITS-1:0] light_y_next;

    color_t in_color;
    logic   grad_valid;
    logic   grad_ready;
    grad_t  grad_data;
    logic   dist_valid;
    logic   dist_ready;
    dist_t  dist_data;
    color_t shade_data;

    logic  sq_valid [SQRT_STAGES+1];
    logic  sq_ready [SQRT_STAGES+1];
    sqrt_t sq_data  [SQRT_STAGES+1];

    assign cfg_ready = 1'b1;

    always_comb begin
        light_x_next = light_x_reg;
        light_y_next = light_y_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_LIGHT_X: light_x_next = cfg_data;
                CFG_LIGHT_Y: light_y_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg <= '0;
            light_y_reg <= '0;
        end else begin
            light_x_reg <= light_x_next;
            light_y_reg <= light_y_next;
        end
    end

    assign in_color.red   = s_tdata[HB+39:HB+32];
    assign in_color.green = s_tdata[HB+47:HB+40];
    assign in_color.blue  = s_tdata[HB+55:HB+48];

    bmap_grad #(
        .COORD_BITS(COORD_BITS)
    ) u_grad (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .light_x      (light_x_reg),
        .light_y      (light_y_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pix_x        (s_tdata[COORD_BITS-1:0]),
        .pix_y        (s_tdata[HB-1:COORD_BITS]),
        .height_right (s_tdata[HB+7:HB]),
        .height_left  (s_tdata[HB+15:HB+8]),
        .height_below (s_tdata[HB+23:HB+16]),
        .height_above (s_tdata[HB+31:HB+24]),
        .color        (in_color),
        .out_valid    (grad_valid),
        .out_ready    (grad_ready),
        .out_data     (grad_data)
    );

    bmap_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (grad_valid),
        .in_ready  (grad_ready),
        .in_data   (grad_data),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_data  (dist_data)
    );

    assign sq_valid[0]        = dist_valid;
    assign dist_ready         = sq_ready[0];
    assign sq_data[0].root_hi = dist_data.root_hi;
    assign sq_data[0].rad     = dist_data.rad;
    assign sq_data[0].sq      = '0;
    assign sq_data[0].color   = dist_data.color;

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
        bmap_sqrt_stage #(
            .FIRST_STEP (i * STEPS_PER_STAGE),
            .NUM_STEPS  ((SQRT_STEPS - i * STEPS_PER_STAGE >= STEPS_PER_STAGE) ?
                         STEPS_PER_STAGE : SQRT_STEPS - i * STEPS_PER_STAGE)
        ) u_sqrt (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    bmap_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid[SQRT_STAGES]),
        .in_ready  (sq_ready[SQRT_STAGES]),
        .in_data   (sq_data[SQRT_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (shade_data)
    );

    assign m_tdata = {shade_data.blue, shade_data.green, shade_data.red};

    // input back pressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_light_x_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_addr == CFG_LIGHT_X) |=> light_x_reg == $past(cfg_data))
        else $error("light x write lost");

    a_light_y_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_addr == CFG_LIGHT_Y) |=> $stable(light_y_reg))
        else $error("light y changed without a write");

endmodule

[tb/sv/tb_env_bump_map_shader_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_env_bump_map_shader_unit
// self-checking bench for the environment mapped bump map shader: pixels go
// in on the stream input with random gaps, shaded colors are checked in order
// against an independent falloff model while the output side stalls at random
// ----------------------------------------------------------------------------
module tb_env_bump_map_shader_unit;
    import bmap_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int TDATA_W = ((2 * CB + 56 + 7) / 8) * 8;
    localparam int MAX_GAP = 19;

    // register indexes with no register behind them
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [CB-1:0] pix_x;
        logic [CB-1:0] pix_y;
        logic [7:0]    height_right;
        logic [7:0]    height_left;
        logic [7:0]    height_below;
        logic [7:0]    height_above;
        color_t        color;
    } pixel_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    // pix_x, pix_y, height_right, height_left, height_below, height_above,
    // color_red, color_green, color_blue
    logic [TDATA_W-1:0]       s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // shaded_red, shaded_green, shaded_blue
    logic [23:0]              m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CB-1:0]            cfg_data  = '0;

    logic [CB-1:0] light_x = '0;
    logic [CB-1:0] light_y = '0;
    bit            gaps_on = 1'b1;

    color_t shaded_q[$];
    int     mismatches = 0;
    int     pixels_sent = 0;
    int     pixels_lit = 0;
    int     shades_checked = 0;

    env_bump_map_shader_unit #(.COORD_BITS(CB)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int draw_gap();
        return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic longint radius_root(longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic int clamp_byte(int val);
        if (val < 0) begin
            return 0;
        end
        if (val > 255) begin
            return 255;
        end
        return val;
    endfunction

    function automatic int light_falloff(pixel_t p);
        int     off_x;
        int     off_y;
        int     dx;
        int     dy;
        longint root;
        off_x = int'(p.pix_x) - int'(light_x) - 128;
        off_y = int'(p.pix_y) - int'(light_y) - 128;
        dx    = clamp_byte(int'(p.height_right) - int'(p.height_left) - off_x) - 128;
        dy    = clamp_byte(int'(p.height_below) - int'(p.height_above) - off_y) - 128;
        root  = radius_root(longint'(dx * dx + dy * dy) << 16);
        if (root >= 32768) begin
            return 0;
        end
        return int'((255 * (32768 - root)) >> 15);
    endfunction

    function automatic color_t shade_pixel(pixel_t p);
        int     fall;
        color_t c;
        fall    = light_falloff(p);
        c.red   = 8'((int'(p.color.red) * fall) >> 8);
        c.green = 8'((int'(p.color.green) * fall) >> 8);
        c.blue  = 8'((int'(p.color.blue) * fall) >> 8);
        return c;
    endfunction

    function automatic pixel_t make_pixel(logic [CB-1:0] x, logic [CB-1:0] y,
                                          logic [7:0] hr, logic [7:0] hl,
                                          logic [7:0] hb, logic [7:0] ha,
                                          logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
        pixel_t p;
        p.pix_x        = x;
        p.pix_y        = y;
        p.height_right = hr;
        p.height_left  = hl;
        p.height_below = hb;
        p.height_above = ha;
        p.color.red    = r;
        p.color.green  = g;
        p.color.blue   = b;
        return p;
    endfunction

    // pixel placed on the light so that u = 128 + hr - hl and v = 128 + hb - ha
    function automatic pixel_t lit_pixel(logic [7:0] hr, logic [7:0] hl,
                                         logic [7:0] hb, logic [7:0] ha,
                                         logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
        return make_pixel(light_x, light_y, hr, hl, hb, ha, r, g, b);
    endfunction

    function automatic pixel_t random_pixel(bit near_light);
        pixel_t p;
        p = make_pixel(CB'($urandom), CB'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom));
        if (near_light) begin
            p.pix_x = light_x + CB'(128) + CB'($urandom_range(0, 320)) - CB'(160);
            p.pix_y = light_y + CB'(128) + CB'($urandom_range(0, 320)) - CB'(160);
        end
        return p;
    endfunction

    function automatic logic [TDATA_W-1:0] pack_pixel(pixel_t p);
        logic [TDATA_W-1:0] d;
        d = '0;
        d[0 +: CB]           = p.pix_x;
        d[CB +: CB]          = p.pix_y;
        d[2 * CB +: 8]       = p.height_right;
        d[2 * CB + 8 +: 8]   = p.height_left;
        d[2 * CB + 16 +: 8]  = p.height_below;
        d[2 * CB + 24 +: 8]  = p.height_above;
        d[2 * CB + 32 +: 8]  = p.color.red;
        d[2 * CB + 40 +: 8]  = p.color.green;
        d[2 * CB + 48 +: 8]  = p.color.blue;
        return d;
    endfunction

    task automatic send_pixel(pixel_t p);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pixel(p);
        do @(posedge aclk); while (!s_tready);
        shaded_q.push_back(shade_pixel(p));
        pixels_sent++;
        if (light_falloff(p) != 0) begin
            pixels_lit++;
        end
    endtask

    task automatic write_register(logic [CFG_ADDR_BITS-1:0] addr, logic [CB-1:0] data,
                                  bit last);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (addr == CFG_LIGHT_X) begin
            light_x = data;
        end else if (addr == CFG_LIGHT_Y) begin
            light_y = data;
        end
        if (last) begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_light(logic [CB-1:0] x, logic [CB-1:0] y);
        if ($urandom_range(0, 1)) begin
            write_register(CFG_LIGHT_X, x, 1'b0);
            write_register(CFG_LIGHT_Y, y, 1'b1);
        end else begin
            write_register(CFG_LIGHT_Y, y, 1'b0);
            write_register(CFG_LIGHT_X, x, 1'b1);
        end
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (shaded_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic test_reset_light();
        send_pixel(make_pixel('0, '0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel('0, '0, 8'd40, 8'd0, 8'd0, 8'd30, 8'd200, 8'd100, 8'd1));
        send_pixel(make_pixel(CB'(128), CB'(128), 8'd0, 8'd0, 8'd0, 8'd0,
                              8'd255, 8'd255, 8'd255));
        drain_pipeline();
    endtask

    task automatic test_field_extremes();
        set_light('1, '1);
        send_pixel(lit_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255));
        send_pixel(lit_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0));
        send_pixel(make_pixel('0, '0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        drain_pipeline();
        set_light('0, '1);
        send_pixel(make_pixel('1, '0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(lit_pixel(8'd10, 8'd20, 8'd30, 8'd5, 8'd255, 8'd255, 8'd255));
        drain_pipeline();
    endtask

    task automatic test_falloff_edges();
        set_light(CB'(2048), CB'(1024));
        // radius exactly 128 along each axis
        send_pixel(lit_pixel(8'd0, 8'd128, 8'd50, 8'd50, 8'd255, 8'd255, 8'd255));
        send_pixel(lit_pixel(8'd77, 8'd77, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255));
        // radius beyond 128 in a corner
        send_pixel(lit_pixel(8'd0, 8'd128, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255));
        // just inside the rim
        send_pixel(lit_pixel(8'd90, 8'd0, 8'd90, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(lit_pixel(8'd127, 8'd0, 8'd128, 8'd128, 8'd255, 8'd128, 8'd64));
        // gradient saturation low and high
        send_pixel(lit_pixel(8'd0, 8'd255, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255));
        send_pixel(lit_pixel(8'd255, 8'd0, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255));
        send_pixel(lit_pixel(8'd1, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255));
        drain_pipeline();
    endtask

    task automatic test_unknown_register();
        write_register(CFG_LIGHT_X, CB'(300), 1'b0);
        write_register(CFG_LIGHT_Y, CB'(700), 1'b0);
        write_register(CFG_SPARE_2, '1, 1'b0);
        write_register(CFG_SPARE_3, '1, 1'b1);
        send_pixel(lit_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd170, 8'd85));
        send_pixel(lit_pixel(8'd20, 8'd0, 8'd0, 8'd20, 8'd255, 8'd255, 8'd255));
        drain_pipeline();
    endtask

    task automatic test_random_shading();
        logic [CB-1:0] lights_x[4] = '{'0, '1, '0, '1};
        logic [CB-1:0] lights_y[4] = '{'0, '1, '1, '0};
        for (int phase = 0; phase < 8; phase++) begin
            if (phase < 4) begin
                set_light(lights_x[phase], lights_y[phase]);
            end else begin
                set_light(CB'($urandom), CB'($urandom));
            end
            for (int n = 0; n < 130; n++) begin
                if (n % 40 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                send_pixel(random_pixel($urandom_range(0, 9) < 7));
            end
            drain_pipeline();
        end
        gaps_on = 1'b1;
    endtask

    // output side: random stalls between results
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        color_t got;
        color_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.red   = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue  = m_tdata[23:16];
            if (shaded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                             got.red, got.green, got.blue);
                end
            end else begin
                want = shaded_q.pop_front();
                shades_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: shade mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 $realtime, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_light();
        test_field_extremes();
        test_falloff_edges();
        test_unknown_register();
        test_random_shading();
        mismatches += shaded_q.size();
        $display("shaded %0d pixels (%0d inside the light radius), %0d results checked",
                 pixels_sent, pixels_lit, shades_checked);
        $display("light positions at all four corners plus random, spare indexes written");
        if (mismatches == 0) begin
            $display("tb_env_bump_map_shader_unit: clean");
        end else begin
            $display("tb_env_bump_map_shader_unit: errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", shaded_q.size());
        $display("tb_env_bump_map_shader_unit: errors");
        $finish;
    end

endmodule
